// ===== rtl/cpt_pkg.sv =====
// Shared constants and arithmetic helpers for the Clarke/Park transform block.
package cpt_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic signed [15:0] KInvSqrt3  = 16'sd18919;
  localparam logic signed [15:0] KTwoThirds = 16'sd21845;
  localparam logic signed [15:0] KOneThird  = 16'sd10923;
  localparam logic [15:0]        SineMax    = 16'd32767;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic [5:0] PolePairsReset = 6'd7;
  localparam logic       RegPolePairs   = 1'b0;

  // Round half up at bit 15, then clamp to 16 bits.
  function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd16384) >>> 15;
    if (t > 48'sd32767) begin
      return 16'sd32767;
    end
    if (t < -48'sd32768) begin
      return -16'sd32768;
    end
    return t[15:0];
  endfunction

  function automatic logic [63:0] q30_step(input logic [63:0] t, input logic [63:0] th2);
    return (t * th2) >> 30;
  endfunction

  // Quarter-wave sine point k of a table with 2^lw entries, Q30 Taylor series.
  function automatic logic [15:0] quarter_sine(input int unsigned k, input int unsigned lw);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] t1, t2, t3, t4, t5, t6, t7, t8, t9;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    th  = (64'(k) * HalfPiQ30) >> lw;
    th2 = (th * th) >> 30;
    t1  = th;
    t2  = q30_step(t1, th2) / 64'd6;
    t3  = q30_step(t2, th2) / 64'd20;
    t4  = q30_step(t3, th2) / 64'd42;
    t5  = q30_step(t4, th2) / 64'd72;
    t6  = q30_step(t5, th2) / 64'd110;
    t7  = q30_step(t6, th2) / 64'd156;
    t8  = q30_step(t7, th2) / 64'd210;
    t9  = q30_step(t8, th2) / 64'd272;
    pos = t1 + t3 + t5 + t7 + t9;
    neg = t2 + t4 + t6 + t8;
    s   = (pos > neg) ? pos - neg : 64'd0;
    r   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (r > 64'd32767) ? SineMax : r[15:0];
  endfunction

endpackage

// ===== rtl/cpt_front.sv =====
// Front end: takes input transfers, forms electrical angle and Clarke beta.
module cpt_front #(
  parameter int ANGLE_BITS = 14,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [95:0]   in_data,
  input  logic [5:0]    pole_pairs,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_data
);
  import cpt_pkg::*;

  logic                  f_v;
  logic signed [15:0]    f_a;
  logic signed [16:0]    f_diff;
  logic signed [15:0]    f_cd;
  logic signed [15:0]    f_cq;
  logic [ANGLE_BITS-1:0] f_elec;
  logic [19:0]           elec_full;
  logic signed [32:0]    beta_prod;
  logic signed [15:0]    beta;

  assign elec_full = 20'(in_data[93:80]) * 20'(pole_pairs);
  assign in_ready  = !f_v || out_ready;
  assign out_valid = f_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (in_ready) begin
      f_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_a    <= $signed(in_data[15:0]);
      f_diff <= 17'($signed(in_data[31:16])) - 17'($signed(in_data[47:32]));
      f_cd   <= $signed(in_data[63:48]);
      f_cq   <= $signed(in_data[79:64]);
      f_elec <= elec_full[ANGLE_BITS-1:0];
    end
  end

  assign beta_prod = f_diff * 33'(KInvSqrt3);
  assign beta      = rnd_sat(48'(beta_prod));
  assign out_data  = {f_elec, f_cq, f_cd, beta, f_a};

endmodule

// ===== rtl/cpt_fifo.sv =====
// Short queue between the front end and the transform pipeline.
module cpt_fifo #(
  parameter int W = 78
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import cpt_pkg::*;

  localparam int PW = $clog2(FifoDepth);

  logic [W-1:0] mem [FifoDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = count != (PW+1)'(FifoDepth);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(FifoDepth)) else $error("fifo overfilled");
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("fifo count lost push");
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("fifo count lost pop");
`endif

endmodule

// ===== rtl/cpt_back.sv =====
// Transform pipeline: sine lookup, Park, inverse Park and inverse Clarke.
module cpt_back #(
  parameter int ANGLE_BITS = 14,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int QW = 78
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [QW-1:0]  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [111:0]   out_data
);
  import cpt_pkg::*;

  localparam int LW = $clog2(SINE_TABLE_DEPTH);
  localparam int IW = LW + 2;

  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g, LW);
  end

  logic adv;
  logic v1, v2, v3, v4, v5;

  logic signed [15:0]    q_a, q_beta, q_cd, q_cq;
  logic [ANGLE_BITS-1:0] q_elec;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         cidx;
  logic [LW:0]           s_addr, c_addr;

  logic signed [15:0] a1, beta1, cd1, cq1;
  logic [15:0]        s_raw, c_raw;
  logic               s_neg, c_neg;
  logic signed [15:0] sn, cs;

  logic signed [15:0] a2, beta2;
  logic signed [31:0] p_acs, p_bsn, p_bcs, p_asn, p_dcs, p_qsn, p_dsn, p_qcs;

  logic signed [15:0] a3, beta3, md3, mq3, ia3, ib3;

  logic signed [15:0] a4, beta4, md4, mq4;
  logic signed [31:0] p_oa, p_ob, p_oc;

  logic signed [15:0] alpha5, beta5, md5, mq5, oa5, ob5, oc5;

  assign adv       = !v5 || out_ready;
  assign in_ready  = adv;
  assign out_valid = v5;

  assign {q_elec, q_cq, q_cd, q_beta, q_a} = in_data;

  assign idx    = IW'({q_elec, {IW{1'b0}}} >> ANGLE_BITS);
  assign cidx   = idx + IW'(SINE_TABLE_DEPTH);
  assign s_addr = idx[IW-2]  ? (LW+1)'(SINE_TABLE_DEPTH) - (LW+1)'(idx[LW-1:0])
                             : (LW+1)'(idx[LW-1:0]);
  assign c_addr = cidx[IW-2] ? (LW+1)'(SINE_TABLE_DEPTH) - (LW+1)'(cidx[LW-1:0])
                             : (LW+1)'(cidx[LW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 1: table read
  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= q_a;
      beta1 <= q_beta;
      cd1   <= q_cd;
      cq1   <= q_cq;
      s_neg <= idx[IW-1];
      c_neg <= cidx[IW-1];
      s_raw <= s_addr[LW] ? SineMax : sine_rom[s_addr[LW-1:0]];
      c_raw <= c_addr[LW] ? SineMax : sine_rom[c_addr[LW-1:0]];
    end
  end

  assign sn = s_neg ? -$signed(s_raw) : $signed(s_raw);
  assign cs = c_neg ? -$signed(c_raw) : $signed(c_raw);

  // stage 2: rotation products
  always_ff @(posedge clk) begin
    if (adv) begin
      a2    <= a1;
      beta2 <= beta1;
      p_acs <= a1 * cs;
      p_bsn <= beta1 * sn;
      p_bcs <= beta1 * cs;
      p_asn <= a1 * sn;
      p_dcs <= cd1 * cs;
      p_qsn <= cq1 * sn;
      p_dsn <= cd1 * sn;
      p_qcs <= cq1 * cs;
    end
  end

  // stage 3: Park and inverse Park sums
  always_ff @(posedge clk) begin
    if (adv) begin
      a3    <= a2;
      beta3 <= beta2;
      md3   <= rnd_sat(48'(p_acs) + 48'(p_bsn));
      mq3   <= rnd_sat(48'(p_bcs) - 48'(p_asn));
      ia3   <= rnd_sat(48'(p_dcs) - 48'(p_qsn));
      ib3   <= rnd_sat(48'(p_dsn) + 48'(p_qcs));
    end
  end

  // stage 4: inverse Clarke products
  always_ff @(posedge clk) begin
    if (adv) begin
      a4    <= a3;
      beta4 <= beta3;
      md4   <= md3;
      mq4   <= mq3;
      p_oa  <= ia3 * KTwoThirds;
      p_ob  <= ib3 * KInvSqrt3;
      p_oc  <= ia3 * KOneThird;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      alpha5 <= a4;
      beta5  <= beta4;
      md5    <= md4;
      mq5    <= mq4;
      oa5    <= rnd_sat(48'(p_oa));
      ob5    <= rnd_sat(48'(p_ob) - 48'(p_oc));
      oc5    <= rnd_sat(-48'(p_oc) - 48'(p_ob));
    end
  end

  assign out_data = {oc5, ob5, oa5, mq5, md5, beta5, alpha5};

endmodule

// ===== rtl/foc_clarke_park_transforms.sv =====
// Top level of the Clarke/Park current transform block.
//
// Input stream (s_*): one transfer carries three phase currents, a d/q command and a
// mechanical angle. Output stream (m_*): one transfer per input with Clarke alpha/beta,
// Park d/q of the currents and the three phase commands from inverse Park and Clarke.
// All values are Q4.11, rounded half up and saturated to 16 bits.
// APB port: register 0 at address 0 holds pole_pairs (6 bits, reset 7).
// Sustained rate is one transfer per cycle while m_tready is high. On the way from input
// transfer to output valid, the front register loads at the input transfer, then the
// queue and five pipeline stages (table read, products, sums, inverse Clarke products,
// output register) each register the item in turn.
// When m_tready is low and an output is valid the pipeline holds; the queue between the
// front end and the pipeline keeps absorbing items until full, then s_tready drops.
// Reset empties the front register, queue and pipeline and sets pole_pairs to 7.
// The sine table is a constant quarter-wave ROM with registered reads.
module foc_clarke_park_transforms #(
  parameter int ANGLE_BITS = 14,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // phase_a, phase_b, phase_c, cmd_d, cmd_q, mech_angle[93:80], zero pad
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // meas_alpha, meas_beta, meas_d, meas_q, out_a, out_b, out_c
  output logic [111:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cpt_pkg::*;

  localparam int QW = 64 + ANGLE_BITS;

  logic [5:0]    pole_pairs;
  logic          f_valid, f_ready;
  logic [QW-1:0] f_data;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPolePairs) ? {26'd0, pole_pairs} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= PolePairsReset;
    end else if (psel && penable && pwrite && paddr[2] == RegPolePairs) begin
      pole_pairs <= pwdata[5:0];
    end
  end

  cpt_front #(.ANGLE_BITS(ANGLE_BITS), .QW(QW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .pole_pairs(pole_pairs),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  cpt_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  cpt_back #(
    .ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .QW(QW)
  ) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule
